// ===== rtl/wsmwh_pkg.sv =====
// Shared types, commands and byte helper functions for the word state mixer.
// No dependencies; every other file in rtl/ uses it.
`timescale 1ns / 1ps
package wsmwh_pkg;

  localparam logic [7:0] ByteKey  = 8'hAA;
  localparam logic [5:0] SixOnes  = 6'h3F;

  typedef struct packed {
    logic       mode;
    logic [5:0] cell_req;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
    logic [5:0] chi_bin;
    logic [2:0] shell_bin;
  } req_t;

  typedef struct packed {
    logic [11:0] omega;
    logic [5:0]  chi0;
    logic [5:0]  chi1;
    logic [5:0]  chi2;
    logic [5:0]  chi3;
    logic [12:0] word_signature;
    logic [11:0] odd_mask;
    logic [11:0] even_mask;
    logic [63:0] step_count;
    logic [6:0]  window_fill;
    logic [6:0]  chi_bin_count;
    logic [6:0]  shell_bin_count;
  } res_t;

  localparam logic MODE_INGEST = 1'b0;
  localparam logic MODE_READ   = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_LOAD, ST_RHIST, ST_STEP,
    ST_OLDRD, ST_OLDWR, ST_NEWRD, ST_NEWWR, ST_FIN
  } state_e;

  typedef struct packed {
    logic cap;
    logic load;
    logic rhist;
    logic step;
    logic old_rd;
    logic old_wr;
    logic new_rd;
    logic new_wr;
    logic fin;
    logic clr;
  } cmd_t;

  typedef struct packed {
    logic oor;
    logic mode;
    logic last;
    logic clr_last;
  } sts_t;

  function automatic logic [5:0] micro_of(input logic [7:0] b);
    logic [7:0] t;
    t = b ^ ByteKey;
    return t[6:1];
  endfunction

  function automatic logic [5:0] eps_a(input logic [7:0] b);
    logic [7:0] t;
    t = b ^ ByteKey;
    return t[0] ? SixOnes : 6'd0;
  endfunction

  function automatic logic [5:0] eps_b(input logic [7:0] b);
    logic [7:0] t;
    t = b ^ ByteKey;
    return t[7] ? SixOnes : 6'd0;
  endfunction

  function automatic logic [2:0] ones6(input logic [5:0] x);
    logic [2:0] n;
    n = 3'd0;
    for (int i = 0; i < 6; i++) n = n + 3'(x[i]);
    return n;
  endfunction

  function automatic logic [11:0] pair_mask(input logic [7:0] b);
    logic [5:0]  m;
    logic [11:0] r;
    m = micro_of(b);
    for (int i = 0; i < 6; i++) r[2*i +: 2] = {2{m[i]}};
    return r;
  endfunction

endpackage

// ===== rtl/wsmwh_ctrl.sv =====
// Sequencer: clearing pass, cell load, histogram read or four window pushes, result.
// Depends on wsmwh_pkg.
`timescale 1ns / 1ps
module wsmwh_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  wsmwh_pkg::sts_t sts_i,
  output wsmwh_pkg::cmd_t cmd_o,
  output logic           busy
);

  wsmwh_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= wsmwh_pkg::ST_CLEAR;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      wsmwh_pkg::ST_CLEAR: if (sts_i.clr_last) state_d = wsmwh_pkg::ST_IDLE;
      wsmwh_pkg::ST_IDLE:  if (start) state_d = wsmwh_pkg::ST_LOAD;
      wsmwh_pkg::ST_LOAD: begin
        if (sts_i.oor)                                state_d = wsmwh_pkg::ST_FIN;
        else if (sts_i.mode == wsmwh_pkg::MODE_READ)  state_d = wsmwh_pkg::ST_RHIST;
        else                                          state_d = wsmwh_pkg::ST_STEP;
      end
      wsmwh_pkg::ST_RHIST: state_d = wsmwh_pkg::ST_FIN;
      wsmwh_pkg::ST_STEP:  state_d = wsmwh_pkg::ST_OLDRD;
      wsmwh_pkg::ST_OLDRD: state_d = wsmwh_pkg::ST_OLDWR;
      wsmwh_pkg::ST_OLDWR: state_d = wsmwh_pkg::ST_NEWRD;
      wsmwh_pkg::ST_NEWRD: state_d = wsmwh_pkg::ST_NEWWR;
      wsmwh_pkg::ST_NEWWR: state_d = sts_i.last ? wsmwh_pkg::ST_FIN : wsmwh_pkg::ST_STEP;
      wsmwh_pkg::ST_FIN:   state_d = wsmwh_pkg::ST_IDLE;
      default:             state_d = wsmwh_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    busy         = 1'b1;
    case (state_q)
      wsmwh_pkg::ST_CLEAR: cmd_o.clr = 1'b1;
      wsmwh_pkg::ST_IDLE: begin
        busy      = 1'b0;
        cmd_o.cap = start;
      end
      wsmwh_pkg::ST_LOAD:  cmd_o.load   = 1'b1;
      wsmwh_pkg::ST_RHIST: cmd_o.rhist  = 1'b1;
      wsmwh_pkg::ST_STEP:  cmd_o.step   = 1'b1;
      wsmwh_pkg::ST_OLDRD: cmd_o.old_rd = 1'b1;
      wsmwh_pkg::ST_OLDWR: cmd_o.old_wr = 1'b1;
      wsmwh_pkg::ST_NEWRD: cmd_o.new_rd = 1'b1;
      wsmwh_pkg::ST_NEWWR: cmd_o.new_wr = 1'b1;
      wsmwh_pkg::ST_FIN:   cmd_o.fin    = 1'b1;
      default:             cmd_o        = '0;
    endcase
  end

endmodule

// ===== rtl/wsmwh_dp.sv =====
// Datapath: per-cell state memory, window ring, chi and shell histograms, mixer.
// Depends on wsmwh_pkg; driven by wsmwh_ctrl commands.
`timescale 1ns / 1ps
module wsmwh_dp #(
  parameter int CELLS  = 64,
  parameter int WINDOW = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  wsmwh_pkg::req_t req_i,
  input  wsmwh_pkg::cmd_t cmd_i,
  output wsmwh_pkg::sts_t sts_o,
  output wsmwh_pkg::res_t res_o,
  output logic            res_valid_o
);

  localparam int CW  = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int PW  = $clog2(WINDOW);
  localparam int FW  = $clog2(WINDOW + 1);
  localparam int CMW = 12 + 64 + PW + FW;
  localparam int CLW = CW + 6;
  localparam logic [CLW-1:0] ClrLast = CLW'(CELLS * 64 - 1);

  // per-cell word: {omega, step, pos, fill}
  logic [CMW-1:0] cell_mem [CELLS];
  logic [5:0]     ring_mem [CELLS * (2 ** PW)];
  logic [6:0]     chist_mem [CELLS * 64];
  logic [6:0]     shist_mem [CELLS * 8];

  wsmwh_pkg::req_t req_q;
  logic [CW-1:0]   cell_q;
  logic            oor_q;
  logic [CLW-1:0]  clr_q;
  logic [CMW-1:0]  cell_rd_q;
  logic [5:0]      ring_rd_q;
  logic [6:0]      chist_rd_q, shist_rd_q;
  logic [11:0]     s_q;
  logic [63:0]     step_q;
  logic [PW-1:0]   pos_q;
  logic [FW-1:0]   fill_q;
  logic [1:0]      k_q;
  logic [5:0]      chi_q [4];
  logic [5:0]      chi_cur_q;
  logic [12:0]     sig_q;
  logic [11:0]     odd_q, even_q;
  wsmwh_pkg::res_t res_q, res_d;
  logic            res_valid_q;

  logic [CW+5:0]   cell_wide;
  logic [CW-1:0]   cell_in;
  logic            oor_in;
  logic [7:0]      byte_cur;
  logic [11:0]     s_d;
  logic [5:0]      chi_d;
  logic            full;
  logic [5:0]      hist_bin;
  logic [CW+5:0]   chist_ra;
  logic [CW+2:0]   shist_ra;

  assign cell_wide = (CW + 6)'(req_i.cell_req);
  assign cell_in   = cell_wide[CW-1:0];
  assign oor_in    = {5'd0, req_i.cell_req} >= 11'(CELLS);
  assign full      = (fill_q == FW'(WINDOW));

  always_comb begin
    case (k_q)
      2'd0:    byte_cur = req_q.byte0;
      2'd1:    byte_cur = req_q.byte1;
      2'd2:    byte_cur = req_q.byte2;
      default: byte_cur = req_q.byte3;
    endcase
  end

  // one byte step: u' = v ^ a, v' = u ^ m ^ e
  assign s_d   = {s_q[5:0] ^ wsmwh_pkg::eps_a(byte_cur),
                  s_q[11:6] ^ wsmwh_pkg::micro_of(byte_cur) ^ wsmwh_pkg::eps_b(byte_cur)};
  assign chi_d = s_d[11:6] ^ s_d[5:0];

  always_comb begin
    if (cmd_i.rhist)       hist_bin = req_q.chi_bin;
    else if (cmd_i.old_rd) hist_bin = ring_rd_q;
    else                   hist_bin = chi_cur_q;
  end
  assign chist_ra = {cell_q, hist_bin};
  assign shist_ra = {cell_q, cmd_i.rhist ? req_q.shell_bin : wsmwh_pkg::ones6(hist_bin)};

  // read ports
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) cell_rd_q <= cell_mem[cell_in];
    if (cmd_i.step) ring_rd_q <= ring_mem[{cell_q, pos_q}];
    if (cmd_i.rhist || cmd_i.old_rd || cmd_i.new_rd) begin
      chist_rd_q <= chist_mem[chist_ra];
      shist_rd_q <= shist_mem[shist_ra];
    end
  end

  // write ports
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) begin
      cell_mem[clr_q[CLW-1:6]]          <= '0;
      chist_mem[clr_q]                  <= '0;
      shist_mem[{clr_q[CLW-1:6], clr_q[2:0]}] <= '0;
    end
    if (cmd_i.fin && !oor_q && req_q.mode == wsmwh_pkg::MODE_INGEST)
      cell_mem[cell_q] <= {s_q, step_q, pos_q, fill_q};
    if (cmd_i.old_wr) begin
      ring_mem[{cell_q, pos_q}] <= chi_cur_q;
      if (full) begin
        chist_mem[{cell_q, ring_rd_q}] <= chist_rd_q - 7'(chist_rd_q != 7'd0);
        shist_mem[{cell_q, wsmwh_pkg::ones6(ring_rd_q)}] <=
          shist_rd_q - 7'(shist_rd_q != 7'd0);
      end
    end
    if (cmd_i.new_wr) begin
      chist_mem[{cell_q, chi_cur_q}]                  <= chist_rd_q + 7'd1;
      shist_mem[{cell_q, wsmwh_pkg::ones6(chi_cur_q)}] <= shist_rd_q + 7'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr) clr_q <= clr_q + CLW'(1);
      res_valid_q <= cmd_i.fin;
    end
  end

  // result word; all zero for an out-of-range cell
  always_comb begin
    res_d = '0;
    if (!oor_q) begin
      res_d.omega       = s_q;
      res_d.step_count  = step_q;
      res_d.window_fill = 7'(fill_q);
      if (req_q.mode == wsmwh_pkg::MODE_READ) begin
        res_d.chi_bin_count   = chist_rd_q;
        res_d.shell_bin_count = (req_q.shell_bin == 3'd7) ? 7'd0 : shist_rd_q;
      end else begin
        res_d.chi0           = chi_q[0];
        res_d.chi1           = chi_q[1];
        res_d.chi2           = chi_q[2];
        res_d.chi3           = chi_q[3];
        res_d.word_signature = sig_q;
        res_d.odd_mask       = odd_q;
        res_d.even_mask      = even_q;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      req_q  <= req_i;
      cell_q <= cell_in;
      oor_q  <= oor_in;
    end
    if (cmd_i.load) begin
      {s_q, step_q, pos_q, fill_q} <= cell_rd_q;
      k_q    <= 2'd0;
      sig_q  <= '0;
      odd_q  <= '0;
      even_q <= '0;
      for (int i = 0; i < 4; i++) chi_q[i] <= '0;
    end
    if (cmd_i.step) begin
      s_q        <= s_d;
      chi_cur_q  <= chi_d;
      chi_q[k_q] <= chi_d;
      // compose byte signature (parity always one) onto running value
      sig_q <= {~sig_q[12], sig_q[5:0] ^ wsmwh_pkg::eps_a(byte_cur),
                sig_q[11:6] ^ wsmwh_pkg::micro_of(byte_cur) ^ wsmwh_pkg::eps_b(byte_cur)};
      if (k_q[0]) even_q <= even_q ^ wsmwh_pkg::pair_mask(byte_cur);
      else        odd_q  <= odd_q ^ wsmwh_pkg::pair_mask(byte_cur);
    end
    if (cmd_i.new_wr) begin
      pos_q  <= (pos_q == PW'(WINDOW - 1)) ? '0 : pos_q + PW'(1);
      if (!full) fill_q <= fill_q + FW'(1);
      step_q <= step_q + 64'd1;
      k_q    <= k_q + 2'd1;
    end
    if (cmd_i.fin) res_q <= res_d;
  end

  assign sts_o.oor      = oor_q;
  assign sts_o.mode     = req_q.mode;
  assign sts_o.last     = (k_q == 2'd3);
  assign sts_o.clr_last = (clr_q == ClrLast);
  assign res_o          = res_q;
  assign res_valid_o    = res_valid_q;

endmodule

// ===== rtl/word_state_mixer_window_histogram.sv =====
// Top level of the word state mixer with windowed chi histograms.
// Depends on wsmwh_pkg, wsmwh_ctrl and wsmwh_dp.
`timescale 1ns / 1ps
// A beat is taken on a rising edge with start high and busy low. After reset the
// block runs a clearing pass over its state and histogram memories, holding busy
// high throughout. Read-mode beats do one histogram read after the cell load and
// out-of-range cells go straight to the result; ingest beats run four serial
// window pushes, each a five-step read-modify-write of the ring and both
// histogram memories through their single ports. Each result is valid on res_o
// for exactly one cycle, flagged by res_valid_o; the receiver cannot stall, so
// capture it in that cycle. The strobe coincides with busy dropping, so a new
// beat may be started in the same cycle the previous result is shown.
module word_state_mixer_window_histogram #(
  parameter int CELLS  = 64,
  parameter int WINDOW = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  wsmwh_pkg::req_t req_i,
  output wsmwh_pkg::res_t res_o,
  output logic            res_valid_o
);

  wsmwh_pkg::cmd_t cmd;
  wsmwh_pkg::sts_t sts;

  // sequencer: owns the state machine and the busy flag
  wsmwh_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  // datapath: memories, mixer and result register
  wsmwh_dp #(
    .CELLS  (CELLS),
    .WINDOW (WINDOW)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_o       (res_o),
    .res_valid_o (res_valid_o)
  );

endmodule

// ===== verif/wsmwh_checker.sv =====
// Checker for the word state mixer: predicts every result from accepted beats
// and compares field by field. Depends on wsmwh_pkg.
`timescale 1ns / 1ps
module wsmwh_checker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            busy_i,
  input  wsmwh_pkg::req_t req_i,
  input  wsmwh_pkg::res_t res_i,
  input  logic            res_valid_i,
  output int              fail_count_o,
  output int              pending_o
);

  localparam int NCELL = 64;
  localparam int DEPTH = 64;

  logic [11:0] cell_state [NCELL];
  logic [63:0] byte_total [NCELL];
  logic [5:0]  ring       [NCELL][DEPTH];
  logic [5:0]  ring_head  [NCELL];
  logic [6:0]  ring_fill  [NCELL];
  logic [6:0]  chi_count  [NCELL][64];
  logic [6:0]  shell_count[NCELL][7];
  wsmwh_pkg::res_t expected_q[$];
  int          fails = 0;
  int          pending = 0;

  assign fail_count_o = fails;
  assign pending_o    = pending;

  function automatic logic [2:0] bit_weight(input logic [5:0] x);
    logic [2:0] n;
    n = 3'd0;
    for (int i = 0; i < 6; i++) n += 3'(x[i]);
    return n;
  endfunction

  function automatic void push_chi(input int c, input logic [5:0] chi);
    logic [5:0] old;
    if (ring_fill[c] >= 7'(DEPTH)) begin
      old = ring[c][ring_head[c]];
      if (chi_count[c][old] != 0) chi_count[c][old]--;
      if (shell_count[c][bit_weight(old)] != 0) shell_count[c][bit_weight(old)]--;
    end else begin
      ring_fill[c]++;
    end
    ring[c][ring_head[c]] = chi;
    chi_count[c][chi]++;
    shell_count[c][bit_weight(chi)]++;
    ring_head[c] = (ring_head[c] == 6'(DEPTH - 1)) ? 6'd0 : ring_head[c] + 6'd1;
  endfunction

  function automatic wsmwh_pkg::res_t mix_word(input wsmwh_pkg::req_t r);
    wsmwh_pkg::res_t o;
    logic [7:0]  b, t;
    logic [5:0]  u, v, un, m, ea, eb, su, sv, tu, tv;
    logic        par, lp;
    logic [11:0] pm;
    int          c;
    o = '0;
    c = r.cell_req;
    if (r.mode == wsmwh_pkg::MODE_INGEST) begin
      u = cell_state[c][11:6];
      v = cell_state[c][5:0];
      par = 1'b0; su = '0; sv = '0;
      for (int k = 0; k < 4; k++) begin
        case (k)
          0: b = r.byte0;
          1: b = r.byte1;
          2: b = r.byte2;
          default: b = r.byte3;
        endcase
        t  = b ^ 8'hAA;
        m  = t[6:1];
        ea = t[0] ? 6'h3F : 6'h00;
        eb = t[7] ? 6'h3F : 6'h00;
        un = v ^ ea;
        v  = u ^ m ^ eb;
        u  = un;
        case (k)
          0: o.chi0 = u ^ v;
          1: o.chi1 = u ^ v;
          2: o.chi2 = u ^ v;
          default: o.chi3 = u ^ v;
        endcase
        byte_total[c]++;
        push_chi(c, u ^ v);
        // compose: swap running taus because every byte has parity one
        lp = 1'b1;
        tu = lp ? sv : su;
        tv = lp ? su : sv;
        su = tu ^ ea;
        sv = tv ^ (m ^ eb);
        par = par ^ lp;
        for (int i = 0; i < 6; i++) pm[2*i +: 2] = {2{m[i]}};
        if (k % 2 == 0) o.odd_mask ^= pm;
        else o.even_mask ^= pm;
      end
      cell_state[c] = {u, v};
      o.word_signature = {par, su, sv};
    end else begin
      o.chi_bin_count = chi_count[c][r.chi_bin];
      o.shell_bin_count = (r.shell_bin < 3'd7) ? shell_count[c][r.shell_bin] : 7'd0;
    end
    o.omega = cell_state[c];
    o.step_count = byte_total[c];
    o.window_fill = ring_fill[c];
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t mismatch on %s: got %0h want %0h", $realtime, what, got, want);
    fails++;
  endtask

  always @(posedge clk_i) begin
    wsmwh_pkg::res_t want, got;
    if (!rst_ni) begin
      expected_q.delete();
      for (int c = 0; c < NCELL; c++) begin
        cell_state[c] = '0; byte_total[c] = '0; ring_head[c] = '0; ring_fill[c] = '0;
        for (int i = 0; i < 64; i++) chi_count[c][i] = '0;
        for (int i = 0; i < 7; i++) shell_count[c][i] = '0;
      end
    end else begin
      // result first: a new beat may be taken on the same edge
      if (res_valid_i) begin
        got = res_i;
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", 64'(got.omega), 64'd0);
        end else begin
          want = expected_q.pop_front();
          if (got.omega != want.omega)
            report_mismatch("omega", 64'(got.omega), 64'(want.omega));
          if (got.chi0 != want.chi0)
            report_mismatch("chi0", 64'(got.chi0), 64'(want.chi0));
          if (got.chi1 != want.chi1)
            report_mismatch("chi1", 64'(got.chi1), 64'(want.chi1));
          if (got.chi2 != want.chi2)
            report_mismatch("chi2", 64'(got.chi2), 64'(want.chi2));
          if (got.chi3 != want.chi3)
            report_mismatch("chi3", 64'(got.chi3), 64'(want.chi3));
          if (got.word_signature != want.word_signature)
            report_mismatch("word_signature", 64'(got.word_signature),
                            64'(want.word_signature));
          if (got.odd_mask != want.odd_mask)
            report_mismatch("odd_mask", 64'(got.odd_mask), 64'(want.odd_mask));
          if (got.even_mask != want.even_mask)
            report_mismatch("even_mask", 64'(got.even_mask), 64'(want.even_mask));
          if (got.step_count != want.step_count)
            report_mismatch("step_count", got.step_count, want.step_count);
          if (got.window_fill != want.window_fill)
            report_mismatch("window_fill", 64'(got.window_fill), 64'(want.window_fill));
          if (got.chi_bin_count != want.chi_bin_count)
            report_mismatch("chi_bin_count", 64'(got.chi_bin_count),
                            64'(want.chi_bin_count));
          if (got.shell_bin_count != want.shell_bin_count)
            report_mismatch("shell_bin_count", 64'(got.shell_bin_count),
                            64'(want.shell_bin_count));
        end
      end
      if (start_i && !busy_i) expected_q.push_back(mix_word(req_i));
    end
    pending = expected_q.size();
  end

endmodule

// ===== verif/testbench.sv =====
// Stimulus and verdict for the word state mixer; the checker does the comparing.
// Depends on wsmwh_pkg, wsmwh_checker and the block's RTL.
`timescale 1ns / 1ps
module testbench;

  localparam int IDLE_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  wsmwh_pkg::req_t req = '0;
  wsmwh_pkg::res_t res;
  logic res_valid;
  int   fail_count, pending;
  int   idle_cycles = 0;

  always #5 clk_i = ~clk_i;

  word_state_mixer_window_histogram u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .req_i(req), .res_o(res), .res_valid_o(res_valid)
  );

  wsmwh_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start), .busy_i(busy), .req_i(req),
    .res_i(res), .res_valid_i(res_valid), .fail_count_o(fail_count),
    .pending_o(pending)
  );

  // Watchdog: count cycles with neither a beat taken nor a result shown.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || res_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Present one beat at the falling edge and hold it until it is taken.
  task automatic send_beat(input wsmwh_pkg::req_t r);
    @(negedge clk_i);
    req   <= r;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
  endtask

  // Drop start once the burst is over.
  task automatic drop_start(input int gap);
    @(negedge clk_i);
    start <= 1'b0;
    repeat (gap) @(negedge clk_i);
  endtask

  function automatic wsmwh_pkg::req_t word_beat(input logic [5:0] c, input logic [31:0] w);
    wsmwh_pkg::req_t r;
    r = '0;
    r.mode = wsmwh_pkg::MODE_INGEST;
    r.cell_req = c;
    {r.byte0, r.byte1, r.byte2, r.byte3} = w;
    r.chi_bin = 6'($urandom);
    r.shell_bin = 3'($urandom);
    return r;
  endfunction

  function automatic wsmwh_pkg::req_t read_beat(input logic [5:0] c, input logic [5:0] cb,
                                                input logic [2:0] sb);
    wsmwh_pkg::req_t r;
    r = '0;
    r.mode = wsmwh_pkg::MODE_READ;
    r.cell_req = c;
    r.chi_bin = cb;
    r.shell_bin = sb;
    {r.byte0, r.byte1, r.byte2, r.byte3} = $urandom;
    return r;
  endfunction

  initial begin
    int burst;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: byte extremes, the key value itself, both modes, both cell ends,
    // shell bin seven and every real shell bin.
    send_beat(word_beat(6'd0, 32'h00000000));
    send_beat(word_beat(6'd0, 32'hFFFFFFFF));
    send_beat(word_beat(6'd63, 32'hAAAAAAAA));
    send_beat(word_beat(6'd63, 32'h55AA01FE));
    send_beat(word_beat(6'd1, 32'h80017F2A));
    for (int s = 0; s < 8; s++) send_beat(read_beat(6'd0, 6'(s * 9), 3'(s)));
    send_beat(read_beat(6'd63, 6'd63, 3'd7));
    send_beat(read_beat(6'd5, 6'd0, 3'd0));
    // Overfill one cell so the window wraps and evicts.
    for (int i = 0; i < 20; i++) send_beat(word_beat(6'd2, $urandom));
    drop_start(3);
    send_beat(read_beat(6'd2, 6'd0, 3'd3));

    // Random: mostly ingest on a few hot cells so windows fill and wrap.
    for (int n = 0; n < 1050; ) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst; b++, n++) begin
        if ($urandom_range(0, 3) == 0)
          send_beat(read_beat($urandom_range(0, 3) == 0 ? 6'($urandom) : 6'($urandom_range(0, 3)),
                              6'($urandom), 3'($urandom)));
        else
          send_beat(word_beat($urandom_range(0, 4) == 0 ? 6'($urandom) : 6'($urandom_range(0, 3)),
                              $urandom));
      end
      drop_start($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40));
    end
    drop_start(0);

    while (pending != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/wsmwh_pkg.sv
rtl/wsmwh_ctrl.sv
rtl/wsmwh_dp.sv
rtl/word_state_mixer_window_histogram.sv
verif/wsmwh_checker.sv
verif/testbench.sv
